// ----- rtl/core/swp_pkg.sv -----
// ----------------------------------------------------------------------------
// swp_pkg
// Shared types and constants of the spline waveform plotter.
// ----------------------------------------------------------------------------
package swp_pkg;

    localparam int SAMPLE_W  = 32;
    localparam int SEG_W     = 10;
    localparam int PIX_W     = 13;
    localparam int CRD_W     = 12;
    localparam int CFG_IDX_W = 3;
    localparam int STEPS     = 32;
    localparam int V_W       = 56;
    localparam int COEF_W    = 37;
    localparam int DIV_STEPS = 12;
    localparam int CNT_W     = 4;

    localparam logic FUNC_PUSH = 1'b0;
    localparam logic FUNC_PLOT = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_LEVEL  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEVEL  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_WIDTH  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_HEIGHT = 3'd5;

    localparam logic [SAMPLE_W-1:0] RST_MIN_LEVEL  = 32'd0;
    localparam logic [SAMPLE_W-1:0] RST_MAX_LEVEL  = 32'd65535;
    localparam logic [CRD_W-1:0]    RST_BOX_WIDTH  = 12'd260;
    localparam logic [CRD_W-1:0]    RST_BOX_HEIGHT = 12'd100;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_COEF1,
        S_COEF2,
        S_CLAMP,
        S_MUL,
        S_DIV,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic             push;
        logic             plot;
        logic             rd_en;
        logic [1:0]       rd_sel;
        logic             cap;
        logic             coef1;
        logic             coef2;
        logic             clamp;
        logic             mul;
        logic             div;
        logic [CNT_W-1:0] div_bit;
        logic             emit;
    } t_cmd;

    typedef struct packed {
        logic plot_ok;
        logic k_last;
    } t_sts;

endpackage

// ----- rtl/core/spline_waveform_plotter.sv -----
// ----------------------------------------------------------------------------
// spline_waveform_plotter
// A push request is taken while idle and leaves busy low. A plot request keeps
// busy high through the four ring reads, the spline coefficient setup and then
// the per-point loop (clamp, multiply, 12-step divider, emit) for every point.
// The next request is taken only after the last point of a plot is emitted.
// A segment outside the window gives no points and leaves busy low.
// Synchronous reset sets the configuration defaults and empties the history.
// ----------------------------------------------------------------------------
module spline_waveform_plotter #(
    parameter int HISTORY_DEPTH = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_func,
    input  logic [swp_pkg::SAMPLE_W-1:0]  i_sample,
    input  logic [swp_pkg::SEG_W-1:0]     i_segment,
    input  logic                          i_cfg_we,
    input  logic [swp_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [swp_pkg::SAMPLE_W-1:0]  i_cfg_data,
    output logic                          o_strobe,
    output logic [swp_pkg::PIX_W-1:0]     o_pixel_x,
    output logic [swp_pkg::PIX_W-1:0]     o_pixel_y,
    output logic                          o_last
);
    import swp_pkg::*;

    t_cmd cmd;
    t_sts sts;

    swp_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_func   (i_func),
        .i_sts    (sts),
        .o_cmd    (cmd),
        .busy     (busy),
        .o_strobe (o_strobe)
    );

    swp_dpath #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_sample   (i_sample),
        .i_segment  (i_segment),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .o_pixel_x  (o_pixel_x),
        .o_pixel_y  (o_pixel_y),
        .o_last     (o_last)
    );

endmodule

// ----- rtl/core/swp_ctrl.sv -----
// ----------------------------------------------------------------------------
// swp_ctrl
// Sequencer: sample reads, coefficient setup and the per-point loop.
// ----------------------------------------------------------------------------
module swp_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    input  logic          i_func,
    input  swp_pkg::t_sts i_sts,
    output swp_pkg::t_cmd o_cmd,
    output logic          busy,
    output logic          o_strobe
);
    import swp_pkg::*;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             accept;

    assign accept = start && (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt + CNT_W'(1);
        case (r_state)
            S_IDLE: begin
                n_cnt = '0;
                if (accept && (i_func == FUNC_PLOT) && i_sts.plot_ok) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                if (r_cnt == CNT_W'(4)) begin
                    n_state = S_COEF1;
                end
            end
            S_COEF1: n_state = S_COEF2;
            S_COEF2: n_state = S_CLAMP;
            S_CLAMP: n_state = S_MUL;
            S_MUL: begin
                n_state = S_DIV;
                n_cnt   = '0;
            end
            S_DIV: begin
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                n_state = i_sts.k_last ? S_IDLE : S_CLAMP;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd         = '0;
        o_cmd.rd_sel  = r_cnt[1:0];
        o_cmd.div_bit = CNT_W'(DIV_STEPS - 1) - r_cnt;
        case (r_state)
            S_IDLE: begin
                o_cmd.push = accept && (i_func == FUNC_PUSH);
                o_cmd.plot = accept && (i_func == FUNC_PLOT);
            end
            S_READ: begin
                o_cmd.rd_en = (r_cnt < CNT_W'(4));
                o_cmd.cap   = (r_cnt != '0);
            end
            S_COEF1: o_cmd.coef1 = 1'b1;
            S_COEF2: o_cmd.coef2 = 1'b1;
            S_CLAMP: o_cmd.clamp = 1'b1;
            S_MUL:   o_cmd.mul   = 1'b1;
            S_DIV:   o_cmd.div   = 1'b1;
            S_EMIT:  o_cmd.emit  = 1'b1;
            default: o_cmd = '0;
        endcase
    end

    assign busy     = (r_state != S_IDLE);
    assign o_strobe = (r_state == S_EMIT);

endmodule

// ----- rtl/core/swp_dpath.sv -----
// ----------------------------------------------------------------------------
// swp_dpath
// History ring, configuration, spline forward differences and pixel mapping.
// ----------------------------------------------------------------------------
module swp_dpath #(
    parameter int HISTORY_DEPTH = 1024
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [swp_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [swp_pkg::SAMPLE_W-1:0]   i_cfg_data,
    input  logic [swp_pkg::SAMPLE_W-1:0]   i_sample,
    input  logic [swp_pkg::SEG_W-1:0]      i_segment,
    input  swp_pkg::t_cmd                  i_cmd,
    output swp_pkg::t_sts                  o_sts,
    output logic [swp_pkg::PIX_W-1:0]      o_pixel_x,
    output logic [swp_pkg::PIX_W-1:0]      o_pixel_y,
    output logic                           o_last
);
    import swp_pkg::*;

    localparam int AW = $clog2(HISTORY_DEPTH);
    localparam int CW = $clog2(HISTORY_DEPTH + 1);
    localparam int PW = ((CW > CRD_W) ? CW : CRD_W) + 1;

    // configuration
    logic [SAMPLE_W-1:0] r_min, r_max;
    logic [CRD_W-1:0]    r_ox, r_oy, r_bw, r_bh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min <= RST_MIN_LEVEL;
            r_max <= RST_MAX_LEVEL;
            r_ox  <= '0;
            r_oy  <= '0;
            r_bw  <= RST_BOX_WIDTH;
            r_bh  <= RST_BOX_HEIGHT;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MIN_LEVEL:  r_min <= i_cfg_data;
                CFG_MAX_LEVEL:  r_max <= i_cfg_data;
                CFG_ORIGIN_X:   r_ox  <= i_cfg_data[CRD_W-1:0];
                CFG_ORIGIN_Y:   r_oy  <= i_cfg_data[CRD_W-1:0];
                CFG_BOX_WIDTH:  r_bw  <= i_cfg_data[CRD_W-1:0];
                CFG_BOX_HEIGHT: r_bh  <= i_cfg_data[CRD_W-1:0];
                default: ;
            endcase
        end
    end

    // history ring
    logic [SAMPLE_W-1:0] mem [HISTORY_DEPTH];
    logic [SAMPLE_W-1:0] r_rd;
    logic [AW-1:0]       r_wp, r_oldest, rd_addr;
    logic [CW-1:0]       r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp     <= '0;
            r_oldest <= '0;
            r_count  <= '0;
        end else if (i_cmd.push) begin
            r_wp <= (r_wp == AW'(HISTORY_DEPTH - 1)) ? '0 : r_wp + AW'(1);
            if (r_count < CW'(HISTORY_DEPTH)) begin
                r_count <= r_count + CW'(1);
            end else begin
                r_oldest <= (r_oldest == AW'(HISTORY_DEPTH - 1)) ? '0
                                                                  : r_oldest + AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            mem[r_wp] <= i_sample;
        end
        if (i_cmd.rd_en) begin
            r_rd <= mem[rd_addr];
        end
    end

    // window size and segment check
    logic [CRD_W-1:0] display, s_now;
    logic [PW-1:0]    s_wide;

    assign display = (r_bw >= CRD_W'(4)) ? r_bw - CRD_W'(4) : '0;
    assign s_wide  = (PW'(r_count) < PW'(display)) ? PW'(r_count) : PW'(display);
    assign s_now   = s_wide[CRD_W-1:0];
    assign o_sts.plot_ok = (s_now >= CRD_W'(2))
                        && (CRD_W'(i_segment) < s_now - CRD_W'(1));

    logic [CRD_W-1:0] r_s;
    logic [SEG_W-1:0] r_i;
    logic [PW-1:0]    r_off;

    // neighbour index, ends replicated
    logic [CRD_W-1:0] ie, idx;
    logic [PW-1:0]    sum;

    assign ie = CRD_W'(r_i);
    always_comb begin
        case (i_cmd.rd_sel)
            2'd0:    idx = (ie != '0) ? ie - CRD_W'(1) : ie;
            2'd1:    idx = ie;
            2'd2:    idx = ie + CRD_W'(1);
            2'd3:    idx = (ie < r_s - CRD_W'(2)) ? ie + CRD_W'(2) : ie + CRD_W'(1);
            default: idx = ie;
        endcase
    end

    assign sum = PW'(r_oldest) + r_off + PW'(idx);
    always_comb begin
        if (sum >= PW'(HISTORY_DEPTH)) begin
            rd_addr = AW'(sum - PW'(HISTORY_DEPTH));
        end else begin
            rd_addr = sum[AW-1:0];
        end
    end

    // clamped samples
    logic [SAMPLE_W-1:0] clip_hi, clip, r_p0, r_p1, r_p2, r_p3;

    assign clip_hi = (r_rd > r_max) ? r_max : r_rd;
    assign clip    = (clip_hi < r_min) ? r_min : clip_hi;

    logic signed [COEF_W-1:0] sp0, sp1, sp2, sp3, r_a, r_b, r_e;

    assign sp0 = $signed({5'b0, r_p0});
    assign sp1 = $signed({5'b0, r_p1});
    assign sp2 = $signed({5'b0, r_p2});
    assign sp3 = $signed({5'b0, r_p3});

    logic signed [V_W-1:0] va, vb, ve, r_v, r_d1, r_d2, r_d3;

    assign va = V_W'(r_a);
    assign vb = V_W'(r_b);
    assign ve = V_W'(r_e);

    // vertical mapping
    logic [SAMPLE_W-1:0]   range_raw, range_v;
    logic [CRD_W-1:0]      span;
    logic signed [V_W-1:0] hi, lo, vc_hi, vc, vdiff;
    logic [47:0]           r_diff, den;
    logic [59:0]           prod, r_rem, dsh;
    logic [DIV_STEPS-1:0]  r_q;

    assign range_raw = (r_max >= r_min) ? r_max - r_min : '0;
    assign range_v   = (range_raw == '0) ? SAMPLE_W'(1) : range_raw;
    assign span      = (r_bh >= CRD_W'(4)) ? r_bh - CRD_W'(4) : '0;
    assign hi        = $signed({8'b0, r_max, 16'b0});
    assign lo        = $signed({8'b0, r_min, 16'b0});
    assign vc_hi     = (r_v > hi) ? hi : r_v;
    assign vc        = (vc_hi < lo) ? lo : vc_hi;
    assign vdiff     = vc - lo;
    assign prod      = r_diff * span;
    assign den       = {range_v, 16'b0};
    assign dsh       = 60'(den) << i_cmd.div_bit;

    // horizontal mapping: quotient and remainder stepped by s
    logic [PIX_W-1:0] r_xq;
    logic [16:0]      r_xr, den_x;
    logic [17:0]      xr_step;
    logic [5:0]       r_k;

    assign den_x   = {r_s - CRD_W'(1), 5'b0};
    assign xr_step = 18'(r_xr) + 18'(r_s);

    always_ff @(posedge i_clk) begin
        if (i_cmd.plot) begin
            r_s   <= s_now;
            r_i   <= i_segment;
            r_off <= PW'(r_count) - PW'(s_now);
            r_xq  <= PIX_W'(i_segment);
            r_xr  <= {2'b0, i_segment, 5'b0};
            r_k   <= '0;
        end
        if (i_cmd.cap) begin
            r_p0 <= r_p1;
            r_p1 <= r_p2;
            r_p2 <= r_p3;
            r_p3 <= clip;
        end
        if (i_cmd.coef1) begin
            r_a <= (sp0 <<< 1) - (sp1 <<< 2) - sp1 + (sp2 <<< 2) - sp3;
            r_b <= (sp1 <<< 1) + sp1 + sp3 - sp0 - (sp2 <<< 1) - sp2;
            r_e <= sp2 - sp0;
        end
        if (i_cmd.coef2) begin
            r_v  <= $signed({8'b0, r_p1, 16'b0});
            r_d1 <= (ve <<< 10) + (va <<< 5) + vb;
            r_d2 <= (va <<< 6) + (vb <<< 2) + (vb <<< 1);
            r_d3 <= (vb <<< 2) + (vb <<< 1);
        end
        if (i_cmd.clamp) begin
            r_diff <= vdiff[47:0];
        end
        if (i_cmd.mul) begin
            r_rem <= prod;
            r_q   <= '0;
        end
        if (i_cmd.div) begin
            if (r_rem >= dsh) begin
                r_rem <= r_rem - dsh;
                r_q   <= r_q | (DIV_STEPS'(1) << i_cmd.div_bit);
            end
        end
        if (i_cmd.emit) begin
            r_v  <= r_v + r_d1;
            r_d1 <= r_d1 + r_d2;
            r_d2 <= r_d2 + r_d3;
            r_k  <= r_k + 6'd1;
            if (xr_step >= 18'(den_x)) begin
                r_xr <= 17'(xr_step - 18'(den_x));
                r_xq <= r_xq + PIX_W'(1);
            end else begin
                r_xr <= xr_step[16:0];
            end
        end
    end

    // ceil of the quotient and the base row
    logic [PIX_W-1:0]  scaled;
    logic signed [13:0] base_y, y_s;

    assign scaled = PIX_W'(r_q) + PIX_W'(r_rem != '0);
    assign base_y = $signed({2'b0, r_oy}) + $signed({2'b0, r_bh}) - 14'sd2;
    assign y_s    = base_y - $signed({1'b0, scaled});

    assign o_sts.k_last = (r_k == 6'(STEPS));
    assign o_last       = o_sts.k_last;
    assign o_pixel_x    = PIX_W'(r_ox) + PIX_W'(2) + r_xq;
    assign o_pixel_y    = y_s[13] ? '0 : y_s[PIX_W-1:0];

endmodule

// ----- tb/swp_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swp_checker
// Watches the request, configuration and point channels of the spline
// waveform plotter, predicts every point and compares it in order.
// ----------------------------------------------------------------------------
module swp_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic                          i_busy,
    input  logic                          i_func,
    input  logic [swp_pkg::SAMPLE_W-1:0]  i_sample,
    input  logic [swp_pkg::SEG_W-1:0]     i_segment,
    input  logic                          i_cfg_we,
    input  logic [swp_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [swp_pkg::SAMPLE_W-1:0]  i_cfg_data,
    input  logic                          i_strobe,
    input  logic [swp_pkg::PIX_W-1:0]     i_pixel_x,
    input  logic [swp_pkg::PIX_W-1:0]     i_pixel_y,
    input  logic                          i_last,
    output int                            o_pending,
    output int                            o_errors,
    output int                            o_points
);
    import swp_pkg::*;

    localparam int DEPTH = 1024;
    localparam int HAW   = $clog2(DEPTH);

    typedef struct packed {
        logic [PIX_W-1:0] x;
        logic [PIX_W-1:0] y;
        logic             last;
    } t_point;

    t_point                point_q[$];
    logic [SAMPLE_W-1:0]   history[DEPTH];
    int unsigned           wr_ptr, old_ptr, n_samples;
    logic [SAMPLE_W-1:0]   lvl_min, lvl_max;
    logic [CRD_W-1:0]      org_x, org_y, box_w, box_h;

    function automatic longint clamped(int unsigned idx);
        longint unsigned c;
        c = history[HAW'((old_ptr + idx) % DEPTH)];
        if (c > lvl_max) c = lvl_max;
        if (c < lvl_min) c = lvl_min;
        return longint'(c);
    endfunction

    task automatic plot_points(int unsigned seg);
        int unsigned shown, s, b;
        longint p0, p1, p2, p3, ca, cb, lo, hi, v, y, base_y;
        longint unsigned rng, den_y, span, num, scaled, den_x, x;
        t_point pt;
        shown = (box_w >= 4) ? box_w - 4 : 0;
        s = (n_samples < shown) ? n_samples : shown;
        if (s < 2 || seg >= s - 1) return;
        b  = n_samples - s;
        // ends of the window repeat their neighbour
        p0 = clamped(b + ((seg > 0) ? seg - 1 : seg));
        p1 = clamped(b + seg);
        p2 = clamped(b + seg + 1);
        p3 = clamped(b + ((seg < s - 2) ? seg + 2 : seg + 1));
        ca = 2 * p0 - 5 * p1 + 4 * p2 - p3;
        cb = -p0 + 3 * p1 - 3 * p2 + p3;
        hi = longint'(lvl_max) * 65536;
        lo = longint'(lvl_min) * 65536;
        rng = (lvl_max >= lvl_min) ? longint'(lvl_max) - longint'(lvl_min) : 0;
        if (rng == 0) rng = 1;
        den_y  = rng * 65536;
        span   = (box_h >= 4) ? box_h - 4 : 0;
        base_y = longint'(org_y) + longint'(box_h) - 2;
        den_x  = longint'(s - 1) * STEPS;
        for (int k = 0; k <= STEPS; k++) begin
            v = 65536 * p1 + 1024 * k * (p2 - p0) + 32 * k * k * ca + k * k * k * cb;
            if (v > hi) v = hi;
            if (v < lo) v = lo;
            num    = longint'(v - lo) * span;
            scaled = (num + den_y - 1) / den_y;
            y = base_y - longint'(scaled);
            if (y < 0) y = 0;
            x = longint'(org_x) + 2 + ((longint'(seg) * STEPS + k) * s) / den_x;
            pt.x    = x[PIX_W-1:0];
            pt.y    = y[PIX_W-1:0];
            pt.last = (k == STEPS);
            point_q.push_back(pt);
        end
    endtask

    always @(posedge i_clk) begin
        t_point want;
        if (!i_rst_n) begin
            point_q.delete();
            wr_ptr = 0; old_ptr = 0; n_samples = 0;
            lvl_min = RST_MIN_LEVEL; lvl_max = RST_MAX_LEVEL;
            org_x = '0; org_y = '0;
            box_w = RST_BOX_WIDTH; box_h = RST_BOX_HEIGHT;
            o_errors = 0; o_points = 0;
        end else begin
            if (i_strobe) begin
                o_points++;
                if (point_q.size() == 0) begin
                    o_errors++;
                    if (o_errors <= 10)
                        $display("unexpected point x=%0d y=%0d last=%0b",
                                 i_pixel_x, i_pixel_y, i_last);
                end else begin
                    want = point_q.pop_front();
                    if (want.x !== i_pixel_x || want.y !== i_pixel_y ||
                        want.last !== i_last) begin
                        o_errors++;
                        if (o_errors <= 10)
                            $display({"point mismatch: exp x=%0d y=%0d last=%0b, ",
                                      "got x=%0d y=%0d last=%0b"},
                                     want.x, want.y, want.last,
                                     i_pixel_x, i_pixel_y, i_last);
                    end
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_MIN_LEVEL:  lvl_min = i_cfg_data;
                    CFG_MAX_LEVEL:  lvl_max = i_cfg_data;
                    CFG_ORIGIN_X:   org_x   = i_cfg_data[CRD_W-1:0];
                    CFG_ORIGIN_Y:   org_y   = i_cfg_data[CRD_W-1:0];
                    CFG_BOX_WIDTH:  box_w   = i_cfg_data[CRD_W-1:0];
                    CFG_BOX_HEIGHT: box_h   = i_cfg_data[CRD_W-1:0];
                    default: ;
                endcase
            end
            if (i_start && !i_busy) begin
                if (i_func == FUNC_PUSH) begin
                    history[HAW'(wr_ptr)] = i_sample;
                    wr_ptr = (wr_ptr + 1) % DEPTH;
                    if (n_samples < DEPTH) n_samples++;
                    else old_ptr = (old_ptr + 1) % DEPTH;
                end else begin
                    plot_points(i_segment);
                end
            end
        end
        o_pending = point_q.size();
    end

endmodule

// ----- tb/tb_spline_waveform_plotter.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_spline_waveform_plotter
// Pushes samples and plots segments under several plot box and level
// settings, with bursty requests; points are checked by swp_checker.
// ----------------------------------------------------------------------------
module tb_spline_waveform_plotter;
    import swp_pkg::*;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic                 i_func = FUNC_PUSH;
    logic [SAMPLE_W-1:0]  i_sample = '0;
    logic [SEG_W-1:0]     i_segment = '0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = CFG_MIN_LEVEL;
    logic [SAMPLE_W-1:0]  i_cfg_data = '0;
    logic                 o_strobe, o_last;
    logic [PIX_W-1:0]     o_pixel_x, o_pixel_y;
    int                   pending, errors, points;
    int                   n_push = 0, n_plot = 0;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    spline_waveform_plotter dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_func(i_func), .i_sample(i_sample), .i_segment(i_segment),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .o_strobe(o_strobe), .o_pixel_x(o_pixel_x), .o_pixel_y(o_pixel_y),
        .o_last(o_last)
    );

    swp_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_busy(busy),
        .i_func(i_func), .i_sample(i_sample), .i_segment(i_segment),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_strobe(o_strobe), .i_pixel_x(o_pixel_x), .i_pixel_y(o_pixel_y),
        .i_last(o_last), .o_pending(pending), .o_errors(errors), .o_points(points)
    );

    // called just after a rising edge; returns just after the accepting edge
    task automatic send(input logic fn, input logic [SAMPLE_W-1:0] smp,
                        input logic [SEG_W-1:0] seg);
        start     <= 1'b1;
        i_func    <= fn;
        i_sample  <= smp;
        i_segment <= seg;
        do @(posedge i_clk); while (busy);
        if (fn == FUNC_PUSH) n_push++;
        else n_plot++;
    endtask

    task automatic drain();
        start <= 1'b0;
        do @(posedge i_clk); while (pending != 0 || busy);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SAMPLE_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_all(input logic [SAMPLE_W-1:0] lmin, input logic [SAMPLE_W-1:0] lmax,
                           input int ox, input int oy, input int w, input int h);
        set_reg(CFG_MIN_LEVEL, lmin);
        set_reg(CFG_MAX_LEVEL, lmax);
        set_reg(CFG_ORIGIN_X, ox);
        set_reg(CFG_ORIGIN_Y, oy);
        set_reg(CFG_BOX_WIDTH, w);
        set_reg(CFG_BOX_HEIGHT, h);
    endtask

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 4))
            0: return $urandom;
            1: return $urandom_range(0, 400);
            2: return $urandom_range(0, 70000);
            3: return 32'hFFFF_FFFF - $urandom_range(0, 3);
            default: return $urandom_range(0, 65535);
        endcase
    endfunction

    // bursts of requests, mostly plots of segments near the window start
    task automatic random_burst(input int items, input int seg_hi);
        int left, blen;
        left = items;
        while (left > 0) begin
            blen = $urandom_range(1, 8);
            for (int j = 0; j < blen && left > 0; j++, left--) begin
                if ($urandom_range(0, 9) < 4)
                    send(FUNC_PUSH, pick_sample(), '0);
                else if ($urandom_range(0, 9) == 0)
                    send(FUNC_PLOT, '0, SEG_W'($urandom));
                else
                    send(FUNC_PLOT, '0, SEG_W'($urandom_range(0, seg_hi)));
            end
            if ($urandom_range(0, 3) != 0) begin
                start <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
        end
    endtask

    initial begin
        #10ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty and single-sample windows give nothing; short windows and out-of-range segments follow
        send(FUNC_PLOT, '0, '0);
        send(FUNC_PUSH, 32'd1000, '0);
        send(FUNC_PLOT, '0, '0);
        send(FUNC_PUSH, 32'd0, '0);
        send(FUNC_PLOT, '0, '0);
        send(FUNC_PUSH, 32'hFFFF_FFFF, '0);
        send(FUNC_PUSH, 32'd65535, '0);
        send(FUNC_PUSH, 32'd30000, '0);
        send(FUNC_PLOT, '0, 10'd0);
        send(FUNC_PLOT, '0, 10'd1);
        send(FUNC_PLOT, '0, 10'd3);
        send(FUNC_PLOT, '0, 10'd4);
        send(FUNC_PLOT, '0, 10'd1022);
        send(FUNC_PLOT, '0, 10'h3FF);
        drain();

        // widest box and full level range
        set_all(32'd0, 32'hFFFF_FFFF, 4095, 4095, 4095, 4095);
        for (int j = 0; j < 30; j++) send(FUNC_PUSH, pick_sample(), '0);
        send(FUNC_PLOT, '0, 10'd0);
        send(FUNC_PLOT, '0, 10'd1021);
        send(FUNC_PLOT, '0, 10'd1022);
        send(FUNC_PLOT, '0, 10'd32);
        random_burst(10, 40);
        drain();

        // zero range, lowest box, narrowest window
        set_all(32'd1000, 32'd1000, 0, 0, 5, 4);
        random_burst(10, 3);
        drain();
        set_reg(CFG_BOX_WIDTH, 32'd6);
        random_burst(15, 2);
        drain();

        // inverted levels
        set_all(32'd70000, 32'd100, 7, 0, 12, 50);
        random_burst(15, 8);
        drain();

        // narrow level band so samples clamp on both sides
        set_all(32'd100, 32'd300, 123, 2000, 40, 300);
        random_burst(20, 36);
        drain();

        // random settings
        for (int ph = 0; ph < 3; ph++) begin
            set_all($urandom_range(0, 40000), $urandom_range(30000, 200000),
                    $urandom_range(0, 4095), $urandom_range(0, 4095),
                    $urandom_range(5, 300), $urandom_range(4, 4095));
            random_burst(15, 40);
            drain();
        end

        set_all(RST_MIN_LEVEL, RST_MAX_LEVEL, 0, 0,
                int'(RST_BOX_WIDTH), int'(RST_BOX_HEIGHT));
        random_burst(10, 255);
        drain();
        repeat (600) @(posedge i_clk);

        $display("covered %0d pushes and %0d plot requests, %0d points checked",
                 n_push, n_plot, points);
        $display("settings ran from narrow to widest box, zero and inverted level ranges");
        if (errors == 0 && pending == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
